FILE: rtl/core/pff_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pff_pkg;

  localparam int unsigned MAX_WORDS = 32;
  localparam int unsigned BUF_AW    = $clog2(MAX_WORDS);
  localparam int unsigned CNT_W     = $clog2(MAX_WORDS + 1);
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned IDX_W     = 12;
  localparam int unsigned OFF_W     = 14;
  localparam int unsigned CHK_W     = 23;
  localparam int unsigned HDR_BYTES = 16;
  localparam logic [CHK_W:0] CHK_MOD = 24'd8388607;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_SENDER_ADDR = 3'd0,
    REG_DST_ADDR    = 3'd1,
    REG_SENDER_PORT = 3'd2,
    REG_DST_PORT    = 3'd3,
    REG_HOP_LIMIT   = 3'd4,
    REG_COMP_MODE   = 3'd5,
    REG_TCLASS      = 3'd6,
    REG_WORDS_PKT   = 3'd7
  } cfg_idx_e;

  // header word selector
  typedef enum logic [1:0] {
    HDR_W0 = 2'd0,
    HDR_W1 = 2'd1,
    HDR_W2 = 2'd2,
    HDR_W3 = 2'd3
  } hdr_sel_e;

  typedef struct packed {
    logic [27:0] sender_addr;
    logic [27:0] dst_addr;
    logic [3:0]  sender_port;
    logic [3:0]  dst_port;
    logic [4:0]  hop_limit;
    logic [1:0]  comp_mode;
    logic [5:0]  tclass;
    logic [5:0]  words_pkt;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic     in_accept;
    logic     sum_en;
    logic     mod_en;
    logic     hdr_load;
    hdr_sel_e hdr_sel;
    logic     rd_en;
    logic     pay_load;
    logic     rd_next;
    logic     pkt_clr;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic close;
    logic out_free;
    logic rd_last;
  } dp_status_t;

endpackage

`default_nettype wire

FILE: rtl/core/pff_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module pff_cfg import pff_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  output cfg_t             cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        REG_SENDER_ADDR: cfg_d.sender_addr = cfg_data_i[27:0];
        REG_DST_ADDR:    cfg_d.dst_addr    = cfg_data_i[27:0];
        REG_SENDER_PORT: cfg_d.sender_port = cfg_data_i[3:0];
        REG_DST_PORT:    cfg_d.dst_port    = cfg_data_i[3:0];
        REG_HOP_LIMIT:   cfg_d.hop_limit   = cfg_data_i[4:0];
        REG_COMP_MODE:   cfg_d.comp_mode   = cfg_data_i[1:0];
        REG_TCLASS:      cfg_d.tclass      = cfg_data_i[5:0];
        REG_WORDS_PKT:   cfg_d.words_pkt   = cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  // all fields zero except the packet size, which starts at 8
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= {28'd0, 28'd0, 4'd0, 4'd0, 5'd0, 2'd0, 6'd0, 6'd8};
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/pff_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module pff_ctrl import pff_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire dp_status_t status_i,
  output dp_cmd_t         cmd_o
);

  typedef enum logic [2:0] {
    ST_COLLECT,
    ST_SUM,
    ST_MOD,
    ST_HDR,
    ST_RD,
    ST_LOAD
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] hdr_cnt_q, hdr_cnt_d;

  assign in_ready_o = (state_q == ST_COLLECT);

  // next state and datapath commands
  always_comb begin
    state_d   = state_q;
    hdr_cnt_d = hdr_cnt_q;
    cmd_o     = '0;
    cmd_o.hdr_sel = hdr_sel_e'(hdr_cnt_q);
    unique case (state_q)
      ST_COLLECT: begin
        if (in_valid_i) begin
          cmd_o.in_accept = 1'b1;
          if (status_i.close) state_d = ST_SUM;
        end
      end
      ST_SUM: begin
        cmd_o.sum_en = 1'b1;
        state_d      = ST_MOD;
      end
      ST_MOD: begin
        cmd_o.mod_en = 1'b1;
        hdr_cnt_d    = '0;
        state_d      = ST_HDR;
      end
      ST_HDR: begin
        if (status_i.out_free) begin
          cmd_o.hdr_load = 1'b1;
          hdr_cnt_d      = hdr_cnt_q + 2'd1;
          if (hdr_sel_e'(hdr_cnt_q) == HDR_W3) state_d = ST_RD;
        end
      end
      ST_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ST_LOAD;
      end
      ST_LOAD: begin
        if (status_i.out_free) begin
          cmd_o.pay_load = 1'b1;
          if (status_i.rd_last) begin
            cmd_o.pkt_clr = 1'b1;
            state_d       = ST_COLLECT;
          end else begin
            cmd_o.rd_next = 1'b1;
            state_d       = ST_RD;
          end
        end
      end
      default: state_d = ST_COLLECT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_COLLECT;
      hdr_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      hdr_cnt_q <= hdr_cnt_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/pff_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module pff_dp import pff_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cfg_t              cfg_i,
  input  wire dp_cmd_t           cmd_i,
  output dp_status_t             status_o,
  input  wire logic [WORD_W-1:0] in_word_i,
  input  wire logic              in_last_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [WORD_W-1:0]      out_word_o,
  output logic                   out_last_o
);

  logic [WORD_W-1:0] buf_mem [MAX_WORDS];

  logic [CNT_W-1:0]  count_q;
  logic [WORD_W-1:0] mag_sum_q;
  logic [IDX_W-1:0]  idx_q;
  logic [OFF_W-1:0]  start_off_q;
  logic [BUF_AW-1:0] rd_idx_q;
  logic [WORD_W-1:0] rd_data_q;
  logic [WORD_W-1:0] chk_q;
  logic              out_valid_q;
  logic [WORD_W-1:0] out_word_q;
  logic              out_last_q;

  logic [CNT_W-1:0]  limit;
  logic [CNT_W-1:0]  count_inc;
  logic [WORD_W-1:0] mag;
  logic [OFF_W-1:0]  pkt_len;
  logic [WORD_W-1:0] chk_sum;
  logic [CHK_W:0]    chk_fold;
  logic [CHK_W:0]    chk_red;
  logic [WORD_W-1:0] hdr_word;

  // packet size clamped to 1..MAX_WORDS
  always_comb begin
    if (cfg_i.words_pkt == '0) begin
      limit = CNT_W'(1);
    end else if (CNT_W'(cfg_i.words_pkt) > CNT_W'(MAX_WORDS)) begin
      limit = CNT_W'(MAX_WORDS);
    end else begin
      limit = CNT_W'(cfg_i.words_pkt);
    end
  end

  assign count_inc = count_q + CNT_W'(1);
  assign mag       = in_word_i[WORD_W-1] ? (WORD_W'(0) - in_word_i) : in_word_i;

  assign status_o.close    = (count_inc >= limit) || in_last_i;
  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign status_o.rd_last  = ({1'b0, rd_idx_q} == (count_q - CNT_W'(1)));

  // header fields
  assign pkt_len = OFF_W'(HDR_BYTES) + OFF_W'({count_q, 2'b00});

  assign chk_sum = mag_sum_q + WORD_W'(cfg_i.sender_addr) + WORD_W'(cfg_i.dst_addr)
                 + WORD_W'(cfg_i.sender_port) + WORD_W'(cfg_i.dst_port)
                 + WORD_W'(start_off_q) + WORD_W'(pkt_len)
                 + WORD_W'(cfg_i.hop_limit) + WORD_W'(cfg_i.comp_mode)
                 + WORD_W'(cfg_i.tclass);

  // mod 2^23-1: fold the high bits onto the low bits, then one subtract
  assign chk_fold = {1'b0, chk_q[CHK_W-1:0]} + (CHK_W+1)'(chk_q[WORD_W-1:CHK_W]);
  assign chk_red  = (chk_fold >= CHK_MOD) ? (chk_fold - CHK_MOD) : chk_fold;

  always_comb begin
    case (cmd_i.hdr_sel)
      HDR_W0:  hdr_word = {cfg_i.sender_addr, cfg_i.dst_addr[27:24]};
      HDR_W1:  hdr_word = {cfg_i.dst_addr[23:0], cfg_i.sender_port, cfg_i.dst_port};
      HDR_W2:  hdr_word = {start_off_q, pkt_len, cfg_i.hop_limit[4:1]};
      HDR_W3:  hdr_word = {cfg_i.hop_limit[0], chk_q[CHK_W-1:0], cfg_i.comp_mode,
                           cfg_i.tclass};
      default: hdr_word = '0;
    endcase
  end

  // payload buffer
  always_ff @(posedge clk_i) begin
    if (cmd_i.in_accept) buf_mem[count_q[BUF_AW-1:0]] <= in_word_i;
    if (cmd_i.rd_en)     rd_data_q <= buf_mem[rd_idx_q];
  end

  // packet bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      mag_sum_q   <= '0;
      idx_q       <= '0;
      start_off_q <= '0;
      rd_idx_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.in_accept) begin
        count_q   <= count_inc;
        mag_sum_q <= mag_sum_q + mag;
        idx_q     <= idx_q + IDX_W'(1);
      end
      if (cmd_i.rd_next) rd_idx_q <= rd_idx_q + BUF_AW'(1);
      if (cmd_i.pkt_clr) begin
        count_q     <= '0;
        mag_sum_q   <= '0;
        rd_idx_q    <= '0;
        start_off_q <= {idx_q, 2'b00};
      end
      if (cmd_i.hdr_load || cmd_i.pay_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // checksum and output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.sum_en) chk_q <= chk_sum;
    if (cmd_i.mod_en) chk_q <= WORD_W'(chk_red);
    if (cmd_i.hdr_load) begin
      out_word_q <= hdr_word;
      out_last_q <= 1'b0;
    end else if (cmd_i.pay_load) begin
      out_word_q <= rd_data_q;
      out_last_q <= status_o.rd_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;
  assign out_last_o  = out_last_q;

endmodule

`default_nettype wire

FILE: rtl/core/packet_fragment_framer.sv
// packet_fragment_framer: packs a stream of signed 32-bit words into packets.
// slave stream s_axis carries one word per item in tdata, tlast closes the
// current packet early. a packet also closes once words_per_packet words
// (clamped to 1..32) are buffered.
// master stream m_axis gives four header words then the buffered payload,
// tlast high on the final payload word of each packet.
// config channel: cfg_valid_i/cfg_ready_o with a register index and data,
// always ready; write only while no packet is in flight.
// input items take one cycle each while collecting; s_axis_tready_o drops
// from the closing item until its packet has been handed to the output
// register. after the closing item the checksum is summed and then reduced
// modulo, the header words are loaded, then each payload word is first read
// from the payload buffer into a register and then loaded into the output
// register.
// reset clears configuration (words_per_packet to 8), counters, the byte
// offset and the output valid; buffer contents are not cleared.
// when m_axis_tready_i is low the output register holds its item and the
// framer waits; collection resumes once the last payload word is loaded.
`timescale 1ns / 1ps
`default_nettype none

module packet_fragment_framer import pff_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // config write channel
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  // input stream
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [31:0] s_axis_tdata_i,   // [31:0] data_word
  input  wire logic        s_axis_tlast_i,   // last_word
  // output stream
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [31:0]      m_axis_tdata_o,   // [31:0] out_word
  output logic             m_axis_tlast_o    // end_of_packet
);

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;

  pff_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  pff_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pff_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_word_i   (s_axis_tdata_i),
    .in_last_i   (s_axis_tlast_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_word_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o)
  );

endmodule

`default_nettype wire
